/* src/hptc_pkg.sv */
// Shared constants and register indexes for the heading PID turn controller.
`timescale 1ns / 1ps
package hptc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd5;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int SETTLE_LIMIT_DEF = 5;

  // angle wrap: 36000 scaled up by 2^18 covers any 34-bit heading difference
  localparam int          WRAP_STEPS = 19;
  localparam logic [33:0] WRAP_TOP   = 34'd9437184000;
  localparam int          WRAP_HALF  = 18000;
  localparam int          WRAP_FULL  = 36000;

  localparam int DIV_STEPS   = 26;
  localparam int SUM_LIMIT   = 50000000;
  localparam int FORCE_BAND  = 800;
  localparam int FORCE_DRIVE = 50;
  localparam int DT_DEFAULT  = 10;

  localparam logic signed [31:0] GAIN_P_RST    = 32'sd65536;
  localparam logic [14:0]        TOLERANCE_RST = 15'd100;
  localparam logic signed [10:0] DRIVE_MIN_RST = -11'sd600;
  localparam logic signed [10:0] DRIVE_MAX_RST = 11'sd600;

endpackage

/* src/heading_pid_turn_controller.sv */
// Heading PID turn controller: angle wrap, serial divide and serial multiply-accumulate.
//
//  channel | signals                                           | dir
//  in      | in_valid in_ready in_op in_heading in_target_angle | in
//          | in_elapsed_ms                                     |
//  out     | out_valid out_ready out_left_drive out_right_drive| out
//          | out_done_res out_busy_res                         |
//  cfg     | cfg_we cfg_index cfg_data                         | in
//
// A start request or an ignored sample goes straight to the emit state. An active sample
// runs the angle wrap, then the rate divider (skipped on the first sample), then the
// bit-serial multiply-accumulate, which dominates.
// Reset is synchronous and restores register and turn state. A new request is taken
// while a result waits; a stalled output holds the finished result in the last state.
`timescale 1ns / 1ps
module heading_pid_turn_controller #(
  parameter int SETTLE_LIMIT = hptc_pkg::SETTLE_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic signed [31:0]               in_heading,
  input  logic signed [23:0]               in_target_angle,
  input  logic [15:0]                      in_elapsed_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [10:0]               out_left_drive,
  output logic signed [10:0]               out_right_drive,
  output logic                             out_done_res,
  output logic                             out_busy_res,
  input  logic                             cfg_we,
  input  logic [hptc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hptc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hptc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_FIXE, S_PREP, S_SUMU, S_DIV, S_MLOAD, S_MUL, S_FIN, S_EMIT
  } state_t;

  state_t state_r;

  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [14:0]        tol_r;
  logic signed [10:0] dmin_r, dmax_r;

  logic signed [32:0] goal_r;
  logic signed [15:0] prior_r;
  logic signed [26:0] sum_r;
  logic               first_r;
  logic [2:0]         settle_r;
  logic               turning_r;

  logic [33:0]        a_r;
  logic [33:0]        wmod_r;
  logic               neg_r;
  logic [15:0]        dt_r;
  logic signed [15:0] e_r;
  logic signed [31:0] prod_r;
  logic [25:0]        num_r;
  logic               num_neg_r;
  logic [16:0]        rem_r;
  logic [25:0]        quo_r;
  logic [4:0]         cnt_r;
  logic [1:0]         phase_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] mcand_r;
  logic [26:0]        mplier_r;

  logic signed [10:0] res_left_r, res_right_r;
  logic               res_done_r, res_busy_r;
  logic               out_valid_r;
  logic signed [10:0] out_left_r, out_right_r;
  logic               out_done_r, out_busy_r;

  logic               in_acc;
  logic signed [33:0] ediff;
  logic signed [16:0] am, e_fix;
  logic signed [16:0] diff;
  logic signed [26:0] num_s;
  logic signed [32:0] sum_w;
  logic [16:0]        rem_sh;
  logic signed [26:0] rate;
  logic signed [63:0] addend;
  logic signed [47:0] v, v_f, v_c;
  logic signed [10:0] v11;
  logic [15:0]        mag;
  logic [2:0]         settle_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_left_drive  = out_left_r;
  assign out_right_drive = out_right_r;
  assign out_done_res    = out_done_r;
  assign out_busy_res    = out_busy_r;

  always_comb begin
    ediff = 34'(goal_r) - 34'(in_heading);
    am = {1'b0, a_r[15:0]};
    if (neg_r) begin
      e_fix = -am;
      if (e_fix < -17'sd18000) e_fix = e_fix + 17'(WRAP_FULL);
    end else begin
      e_fix = am;
      if (am > 17'(WRAP_HALF)) e_fix = am - 17'(WRAP_FULL);
    end
    diff  = 17'(e_r) - 17'(prior_r);
    num_s = 27'(diff) * 27'sd1000;
    sum_w = 33'(sum_r) + 33'(prod_r);
    rem_sh = {rem_r[15:0], num_r[25]};
    rate = num_neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    addend = mplier_r[0] ? mcand_r : 64'sd0;
    v = acc_r[63:16];
    v_f = v;
    if (e_r > 16'(FORCE_BAND) && v < 48'(FORCE_DRIVE)) v_f = 48'(FORCE_DRIVE);
    if (e_r < -16'sd800 && v > -48'sd50) v_f = -48'sd50;
    v_c = v_f;
    if (v_c < 48'(dmin_r)) v_c = 48'(dmin_r);
    if (v_c > 48'(dmax_r)) v_c = 48'(dmax_r);
    v11 = v_c[10:0];
    mag = e_r[15] ? 16'(-e_r) : 16'(e_r);
    if (mag < {1'b0, tol_r}) settle_nxt = (settle_r == 3'd7) ? settle_r : settle_r + 3'd1;
    else settle_nxt = 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      tol_r       <= TOLERANCE_RST;
      dmin_r      <= DRIVE_MIN_RST;
      dmax_r      <= DRIVE_MAX_RST;
      goal_r      <= '0;
      prior_r     <= '0;
      sum_r       <= '0;
      first_r     <= 1'b1;
      settle_r    <= '0;
      turning_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:    gain_p_r <= cfg_data;
          REG_GAIN_I:    gain_i_r <= cfg_data;
          REG_GAIN_D:    gain_d_r <= cfg_data;
          REG_TOLERANCE: tol_r    <= cfg_data[14:0];
          REG_DRIVE_MIN: dmin_r   <= cfg_data[10:0];
          REG_DRIVE_MAX: dmax_r   <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            dt_r <= (in_elapsed_ms <= 16'd1) ? 16'(DT_DEFAULT) : in_elapsed_ms;
            res_left_r  <= '0;
            res_right_r <= '0;
            res_done_r  <= 1'b0;
            if (in_op == OP_START) begin
              goal_r    <= 33'(in_heading) + 33'(in_target_angle);
              sum_r     <= '0;
              prior_r   <= '0;
              first_r   <= 1'b1;
              settle_r  <= '0;
              turning_r <= 1'b1;
              res_busy_r <= 1'b1;
              state_r   <= S_EMIT;
            end else if (!turning_r) begin
              res_busy_r <= 1'b0;
              state_r    <= S_EMIT;
            end else begin
              neg_r   <= ediff[33];
              a_r     <= ediff[33] ? 34'(-ediff) : 34'(ediff);
              wmod_r  <= WRAP_TOP;
              cnt_r   <= 5'(WRAP_STEPS - 1);
              state_r <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          if (a_r >= wmod_r) a_r <= a_r - wmod_r;
          wmod_r <= wmod_r >> 1;
          cnt_r  <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= S_FIXE;
        end
        S_FIXE: begin
          e_r     <= e_fix[15:0];
          state_r <= S_PREP;
        end
        S_PREP: begin
          prod_r    <= 32'(e_r) * 32'($signed({1'b0, dt_r}));
          num_neg_r <= num_s[26];
          num_r     <= num_s[26] ? 26'(-num_s) : num_s[25:0];
          state_r   <= S_SUMU;
        end
        S_SUMU: begin
          if (sum_w > 33'(SUM_LIMIT)) sum_r <= 27'(SUM_LIMIT);
          else if (sum_w < -33'sd50000000) sum_r <= -27'sd50000000;
          else sum_r <= sum_w[26:0];
          acc_r   <= '0;
          rem_r   <= '0;
          quo_r   <= '0;
          phase_r <= '0;
          cnt_r   <= 5'(DIV_STEPS - 1);
          state_r <= first_r ? S_MLOAD : S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sh >= {1'b0, dt_r}) begin
            rem_r <= rem_sh - {1'b0, dt_r};
            quo_r <= {quo_r[24:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[24:0], 1'b0};
          end
          num_r <= num_r << 1;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= S_MLOAD;
        end
        S_MLOAD: begin
          case (phase_r)
            2'd0: begin
              mcand_r  <= 64'(gain_p_r);
              mplier_r <= 27'(e_r);
              cnt_r    <= 5'd15;
            end
            2'd1: begin
              mcand_r  <= 64'(gain_i_r);
              mplier_r <= sum_r;
              cnt_r    <= 5'd26;
            end
            default: begin
              mcand_r  <= 64'(gain_d_r);
              mplier_r <= rate;
              cnt_r    <= 5'd26;
            end
          endcase
          state_r <= S_MUL;
        end
        S_MUL: begin
          // sign bit of the multiplier carries negative weight
          if (cnt_r == 5'd0) acc_r <= acc_r - addend;
          else acc_r <= acc_r + addend;
          mcand_r  <= mcand_r <<< 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            if (phase_r == 2'd2) state_r <= S_FIN;
            else begin
              phase_r <= phase_r + 2'd1;
              state_r <= S_MLOAD;
            end
          end
        end
        S_FIN: begin
          prior_r  <= e_r;
          first_r  <= 1'b0;
          settle_r <= settle_nxt;
          if (32'(settle_nxt) > 32'(SETTLE_LIMIT)) begin
            turning_r   <= 1'b0;
            res_done_r  <= 1'b1;
            res_busy_r  <= 1'b0;
            res_left_r  <= '0;
            res_right_r <= '0;
          end else begin
            res_done_r  <= 1'b0;
            res_busy_r  <= 1'b1;
            res_right_r <= v11;
            res_left_r  <= (v11 == -11'sd1024) ? 11'sd1023 : -v11;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_left_r  <= res_left_r;
            out_right_r <= res_right_r;
            out_done_r  <= res_done_r;
            out_busy_r  <= res_busy_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_left_drive == 11'sd0 && out_right_drive == 11'sd0)
    else $error("done result with nonzero drive");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_done_res && out_busy_res))
    else $error("done and busy both set");

  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_drive == -out_right_drive) ||
                  (out_right_drive == -11'sd1024 && out_left_drive == 11'sd1023))
    else $error("left drive not mirror of right drive");

  a_start_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_START |=> state_r == S_EMIT && turning_r)
    else $error("start request did not arm turn");

endmodule
